@@ sv/lsas_pkg.sv @@
package lsas_pkg;

    localparam int NUM_SECTORS = 13;
    localparam int NUM_GROUPS  = 5;
    localparam int GROUP_W     = $clog2(NUM_GROUPS + 1);
    localparam int IDX_W       = $clog2(NUM_SECTORS + 1);
    localparam int SIDE_K      = (NUM_SECTORS - 1) / 4;
    localparam int CENTER_IDX  = (NUM_SECTORS - 1) / 2;

    localparam int DIST_W  = 16;
    localparam int SPEED_W = 16;
    localparam int TURN_W  = 8;
    localparam int COUNT_W = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [DIST_W-1:0] FAR_RANGE = 16'd2560;
    localparam int SIM_LIMIT = 76;

    localparam logic [DIST_W-1:0] NEAR_LIMIT  = 16'd384;
    localparam logic [DIST_W-1:0] CLOSE_LIMIT = 16'd512;
    localparam logic [DIST_W-1:0] WARN_LIMIT  = 16'd640;

    localparam logic signed [SPEED_W-1:0] FAST_SPEED   = 16'sd512;
    localparam logic signed [SPEED_W-1:0] NEAR_SPEED   = 16'sd128;
    localparam logic signed [SPEED_W-1:0] CLOSE_SPEED  = 16'sd256;
    localparam logic signed [SPEED_W-1:0] WARN_SPEED   = 16'sd384;
    localparam logic signed [SPEED_W-1:0] CREEP_SPEED  = 16'sd26;
    localparam logic signed [SPEED_W+1:0] RAMP_STEP    = 18'sd256;

    localparam logic signed [TURN_W-1:0] TURN_SPIN  = 8'sd100;
    localparam logic signed [TURN_W-1:0] TURN_NEAR  = 8'sd100;
    localparam logic signed [TURN_W-1:0] TURN_CLOSE = 8'sd75;
    localparam logic signed [TURN_W-1:0] TURN_WARN  = 8'sd50;
    localparam logic signed [TURN_W-1:0] TURN_CLEAR = 8'sd1;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_SECTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SPEED       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HELPER_ON          = 2'd2;

    typedef logic [DIST_W-1:0] t_dist;
    typedef t_dist [NUM_GROUPS-1:0] t_group_set;

    typedef struct packed {
        logic signed [SPEED_W-1:0] target_speed;
        logic                      helper_on;
    } t_steer_cfg;

    function automatic logic [GROUP_W-1:0] group_of(input logic [IDX_W-1:0] raw);
        int r;
        logic [GROUP_W-1:0] g;
        r = int'(raw);
        if (r < SIDE_K) begin
            g = GROUP_W'(0);
        end else if (r < 2 * SIDE_K) begin
            g = GROUP_W'(1);
        end else if (r == CENTER_IDX) begin
            g = GROUP_W'(2);
        end else if (r > CENTER_IDX && r <= CENTER_IDX + SIDE_K) begin
            g = GROUP_W'(3);
        end else if (r > CENTER_IDX + SIDE_K && r <= CENTER_IDX + 2 * SIDE_K) begin
            g = GROUP_W'(4);
        end else begin
            g = GROUP_W'(NUM_GROUPS);
        end
        return g;
    endfunction

endpackage

@@ sv/lsas_front.sv @@
module lsas_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [lsas_pkg::DIST_W-1:0]      i_range_value,
    input  logic                             i_end_of_scan,
    input  logic [lsas_pkg::COUNT_W-1:0]     i_samples_per_sector,
    output logic                             o_push,
    output lsas_pkg::t_group_set             o_push_groups
);
    import lsas_pkg::*;

    logic [DIST_W-1:0]  r_raw_min, n_raw_min;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0]   r_index, n_index;
    t_group_set         r_groups, n_groups;

    logic [COUNT_W-1:0] per;
    logic [COUNT_W-1:0] count_inc;
    logic [DIST_W-1:0]  raw_new;
    logic [GROUP_W-1:0] grp;
    logic               in_range;
    logic               full;
    logic               fold;
    t_group_set         folded;

    always_comb begin
        per       = (i_samples_per_sector == '0) ? COUNT_W'(1) : i_samples_per_sector;
        count_inc = r_count + COUNT_W'(1);
        raw_new   = (i_range_value < r_raw_min) ? i_range_value : r_raw_min;
        in_range  = r_index < IDX_W'(NUM_SECTORS);
        full      = count_inc >= per;
        fold      = in_range && (full || i_end_of_scan);
        grp       = group_of(r_index);
        for (int i = 0; i < NUM_GROUPS; i++) begin
            folded[i] = (fold && grp == GROUP_W'(i) && raw_new < r_groups[i])
                      ? raw_new : r_groups[i];
        end

        n_raw_min = r_raw_min;
        n_count   = r_count;
        n_index   = r_index;
        n_groups  = r_groups;
        if (i_accept) begin
            if (i_end_of_scan) begin
                n_raw_min = FAR_RANGE;
                n_count   = '0;
                n_index   = '0;
                for (int i = 0; i < NUM_GROUPS; i++) begin
                    n_groups[i] = FAR_RANGE;
                end
            end else begin
                n_groups = folded;
                if (in_range) begin
                    if (full) begin
                        n_raw_min = FAR_RANGE;
                        n_count   = '0;
                        n_index   = r_index + IDX_W'(1);
                    end else begin
                        n_raw_min = raw_new;
                        n_count   = count_inc;
                    end
                end
            end
        end
    end

    assign o_push        = i_accept && i_end_of_scan;
    assign o_push_groups = folded;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_min <= FAR_RANGE;
            r_count   <= '0;
            r_index   <= '0;
            for (int i = 0; i < NUM_GROUPS; i++) begin
                r_groups[i] <= FAR_RANGE;
            end
        end else begin
            r_raw_min <= n_raw_min;
            r_count   <= n_count;
            r_index   <= n_index;
            r_groups  <= n_groups;
        end
    end

endmodule

@@ sv/lsas_queue.sv @@
module lsas_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lsas_pkg::t_group_set i_push_groups,
    output logic                 o_push_ready,
    input  logic                 i_pop,
    output logic                 o_pop_valid,
    output lsas_pkg::t_group_set o_pop_groups
);
    import lsas_pkg::*;

    t_group_set  r_entry [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_fill, n_fill;
    logic        do_push;
    logic        do_pop;

    assign o_push_ready = r_fill != 2'd2;
    assign o_pop_valid  = r_fill != 2'd0;
    assign o_pop_groups = r_entry[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_comb begin
        n_wr_ptr = do_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? !r_rd_ptr : r_rd_ptr;
        n_fill   = r_fill + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_push_groups;
        end
    end

endmodule

@@ sv/lsas_back.sv @@
module lsas_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lsas_pkg::t_steer_cfg                i_cfg,
    input  logic                                i_req_valid,
    input  lsas_pkg::t_group_set                i_req_groups,
    output logic                                o_req_take,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [lsas_pkg::SPEED_W-1:0] o_linear_speed,
    output logic signed [lsas_pkg::TURN_W-1:0]  o_angular_rate,
    output logic [lsas_pkg::DIST_W-1:0]         o_front_distance
);
    import lsas_pkg::*;

    localparam int DIFF_W = DIST_W + 1;
    localparam logic signed [DIFF_W-1:0] LIM_POS = DIFF_W'(SIM_LIMIT);
    localparam logic signed [DIFF_W-1:0] LIM_NEG = -DIFF_W'(SIM_LIMIT);

    logic                      r_valid;
    logic signed [SPEED_W-1:0] r_speed, n_speed;
    logic signed [TURN_W-1:0]  r_turn, n_turn;
    logic [DIST_W-1:0]         r_front;
    logic signed [SPEED_W-1:0] r_last_speed;

    logic signed [DIFF_W-1:0]  diff_in;
    logic signed [DIFF_W-1:0]  diff_out;
    logic signed [DIFF_W-1:0]  diff;
    logic                      sim_in;
    logic                      sim_out;
    logic signed [SPEED_W+1:0] ramp;
    logic signed [SPEED_W+1:0] target_ext;
    logic [DIST_W-1:0]         centre;
    logic signed [TURN_W-1:0]  factor;
    logic                      fast;

    assign o_req_take = i_req_valid && (!r_valid || i_ready);

    always_comb begin
        centre   = i_req_groups[2];
        diff_in  = $signed({1'b0, i_req_groups[1]}) - $signed({1'b0, i_req_groups[3]});
        diff_out = $signed({1'b0, i_req_groups[0]}) - $signed({1'b0, i_req_groups[4]});
        sim_in   = diff_in >= LIM_NEG && diff_in <= LIM_POS;
        sim_out  = diff_out >= LIM_NEG && diff_out <= LIM_POS;
        diff     = sim_in ? diff_out : diff_in;
        ramp       = {{2{r_last_speed[SPEED_W-1]}}, r_last_speed} + RAMP_STEP;
        target_ext = {{2{i_cfg.target_speed[SPEED_W-1]}}, i_cfg.target_speed};
        fast       = i_cfg.helper_on && i_cfg.target_speed >= FAST_SPEED;

        n_speed = i_cfg.target_speed;
        if (centre < NEAR_LIMIT) begin
            factor = TURN_NEAR;
            if (fast) n_speed = NEAR_SPEED;
        end else if (centre < CLOSE_LIMIT) begin
            factor = TURN_CLOSE;
            if (fast) n_speed = CLOSE_SPEED;
        end else if (centre < WARN_LIMIT) begin
            factor = TURN_WARN;
            if (fast) n_speed = WARN_SPEED;
        end else if (ramp < target_ext) begin
            factor = TURN_WARN;
            if (i_cfg.helper_on) n_speed = ramp[SPEED_W-1:0];
        end else begin
            factor = TURN_CLEAR;
        end

        if (diff == '0) begin
            n_turn = '0;
        end else if (diff[DIFF_W-1]) begin
            n_turn = factor;
        end else begin
            n_turn = -factor;
        end

        if (sim_in && sim_out) begin
            n_speed = CREEP_SPEED;
            n_turn  = TURN_SPIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_last_speed <= '0;
        end else begin
            if (o_req_take) begin
                r_valid      <= 1'b1;
                r_last_speed <= n_speed;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_take) begin
            r_speed <= n_speed;
            r_turn  <= n_turn;
            r_front <= centre;
        end
    end

    assign o_valid          = r_valid;
    assign o_linear_speed   = r_speed;
    assign o_angular_rate   = r_turn;
    assign o_front_distance = r_front;

endmodule

@@ sv/lidar_sector_avoidance_steering_top.sv @@
// Channel  Handshake               Payload
// input    i_valid / o_ready       i_range_value, i_end_of_scan
// output   o_valid / i_ready       o_linear_speed, o_angular_rate, o_front_distance
// config   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One sample per cycle while o_ready is high; each accepted sample updates the sector and group minima.
// An end-of-scan sample's group minima are written into the decision queue, then taken into the output register.
// A two-entry decision queue sits between the sector tracker and the steering unit,
// so o_ready drops only when two decisions wait behind a stalled output.
// Synchronous active-low reset; no clearing pass.
module lidar_sector_avoidance_steering_top (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic [lsas_pkg::DIST_W-1:0]              i_range_value,
    input  logic                                     i_end_of_scan,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic signed [lsas_pkg::SPEED_W-1:0]      o_linear_speed,
    output logic signed [lsas_pkg::TURN_W-1:0]       o_angular_rate,
    output logic [lsas_pkg::DIST_W-1:0]              o_front_distance,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [lsas_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [lsas_pkg::CFG_DATA_W-1:0]          i_cfg_data
);
    import lsas_pkg::*;

    logic [COUNT_W-1:0] r_samples_per_sector;
    t_steer_cfg         r_cfg;
    logic               accept;
    logic               push;
    t_group_set         push_groups;
    logic               push_ready;
    logic               pop;
    logic               pop_valid;
    t_group_set         pop_groups;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = push_ready;
    assign accept      = i_valid && push_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples_per_sector <= COUNT_W'(55);
            r_cfg.target_speed   <= '0;
            r_cfg.helper_on      <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SAMPLES_PER_SECTOR: r_samples_per_sector <= i_cfg_data[COUNT_W-1:0];
                CFG_TARGET_SPEED:       r_cfg.target_speed   <= $signed(i_cfg_data);
                CFG_HELPER_ON:          r_cfg.helper_on      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    lsas_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_accept             (accept),
        .i_range_value        (i_range_value),
        .i_end_of_scan        (i_end_of_scan),
        .i_samples_per_sector (r_samples_per_sector),
        .o_push               (push),
        .o_push_groups        (push_groups)
    );

    lsas_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_push_groups (push_groups),
        .o_push_ready  (push_ready),
        .i_pop         (pop),
        .o_pop_valid   (pop_valid),
        .o_pop_groups  (pop_groups)
    );

    lsas_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_req_valid      (pop_valid),
        .i_req_groups     (pop_groups),
        .o_req_take       (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_linear_speed   (o_linear_speed),
        .o_angular_rate   (o_angular_rate),
        .o_front_distance (o_front_distance)
    );

endmodule
